[src/corrk4_pkg.sv]
`timescale 1ns / 1ps
package corrk4_pkg;

  // Default sizes of the ring and of the tanh table.
  localparam int N_OSC_DEF        = 8;
  localparam int TANH_ENTRIES_DEF = 256;

  // Field widths.
  localparam int IDX_W   = 6;
  localparam int PHASE_W = 32;
  localparam int RATE_W  = 24;
  localparam int STEP_W  = 20;
  localparam int TANH_W  = 22;
  localparam int SUM_W   = 32;
  localparam int SLOPE_W = 26;

  localparam logic [STEP_W-1:0] STEP_RESET = 20'd17476;

  // Opcodes of an input transaction.
  localparam logic OPC_LOAD = 1'b0;
  localparam logic OPC_STEP = 1'b1;

  // Runge-Kutta stage numbers.
  localparam logic [1:0] STAGE_K1 = 2'd0;
  localparam logic [1:0] STAGE_K2 = 2'd1;
  localparam logic [1:0] STAGE_K3 = 2'd2;
  localparam logic [1:0] STAGE_K4 = 2'd3;

  typedef struct packed {
    logic                      opcode;
    logic [IDX_W-1:0]          oscillator_index;
    logic signed [PHASE_W-1:0] phase_value;
    logic signed [RATE_W-1:0]  natural_rate;
    logic signed [RATE_W-1:0]  coupling_gain;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]          result_index;
    logic signed [PHASE_W-1:0] result_phase;
    logic                      last_of_run;
  } out_item_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_PRE, OP_CAP, OP_RD, OP_TANH, OP_MUL1, OP_SLOPE,
    OP_MUL2, OP_UPD, OP_FRD, OP_FMUL, OP_FDIV, OP_FOUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] idx_nx;
    logic             last;
    logic [1:0]       stage;
  } cmd_t;

  // Tanh of a Q.20 argument, worked out at elaboration for the table.
  function automatic logic signed [TANH_W-1:0] tanh_fixed(input longint x);
    logic [63:0] t;
    logic [63:0] one;
    logic [63:0] v;
    logic [63:0] v2;
    logic [63:0] v3;
    logic [63:0] v4;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] quo;
    t   = (x < 0) ? 64'(-x) : 64'(x);
    one = 64'd1 << 30;
    v   = (t << 1) << 4;
    v2  = (v * v) >> 30;
    v3  = (v2 * v) >> 30;
    v4  = (v3 * v) >> 30;
    e   = one - v + v2 / 2 - v3 / 6 + v4 / 24;
    for (int k = 0; k < 6; k++) e = (e * e) >> 30;
    den = one + e;
    num = ((one - e) << 20) + (den >> 1);
    // Restoring long division.
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return (x < 0) ? -$signed(quo[TANH_W-1:0]) : $signed(quo[TANH_W-1:0]);
  endfunction

endpackage

[src/corrk4_ctrl.sv]
`timescale 1ns / 1ps
module corrk4_ctrl #(
  parameter int N_OSC = corrk4_pkg::N_OSC_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              opcode,
  output logic              busy,
  output corrk4_pkg::cmd_t  cmd
);
  import corrk4_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_PRE   = 13'b0000000000010,
    S_CAP   = 13'b0000000000100,
    S_RD    = 13'b0000000001000,
    S_TANH  = 13'b0000000010000,
    S_MUL1  = 13'b0000000100000,
    S_SLOPE = 13'b0000001000000,
    S_MUL2  = 13'b0000010000000,
    S_UPD   = 13'b0000100000000,
    S_FRD   = 13'b0001000000000,
    S_FMUL  = 13'b0010000000000,
    S_FDIV  = 13'b0100000000000,
    S_FOUT  = 13'b1000000000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [1:0]       stage_r, stage_nxt;
  logic             last;

  assign last = (idx_r == IDX_W'(N_OSC - 1));
  assign busy = (state_r != S_IDLE);

  // Sequencing of stages, oscillators and the final update pass.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    stage_nxt = stage_r;
    unique case (state_r)
      S_IDLE: begin
        if (start && (opcode == OPC_STEP)) begin
          state_nxt = S_PRE;
          idx_nxt   = '0;
          stage_nxt = STAGE_K1;
        end
      end
      S_PRE:   state_nxt = S_CAP;
      S_CAP:   state_nxt = S_RD;
      S_RD:    state_nxt = S_TANH;
      S_TANH:  state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_SLOPE;
      S_SLOPE: state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_UPD;
      S_UPD: begin
        idx_nxt = last ? '0 : idx_r + 1'b1;
        if (!last) begin
          state_nxt = S_RD;
        end else if (stage_r == STAGE_K4) begin
          state_nxt = S_FRD;
        end else begin
          state_nxt = S_PRE;
          stage_nxt = stage_r + 1'b1;
        end
      end
      S_FRD:  state_nxt = S_FMUL;
      S_FMUL: state_nxt = S_FDIV;
      S_FDIV: state_nxt = S_FOUT;
      S_FOUT: begin
        idx_nxt   = last ? '0 : idx_r + 1'b1;
        state_nxt = last ? S_IDLE : S_FRD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      stage_r <= STAGE_K1;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      stage_r <= stage_nxt;
    end
  end

  // Command to the datapath.
  always_comb begin
    cmd.idx    = idx_r;
    cmd.idx_nx = last ? '0 : idx_r + 1'b1;
    cmd.last   = last;
    cmd.stage  = stage_r;
    unique case (state_r)
      S_IDLE:  cmd.op = (start && (opcode == OPC_LOAD)) ? OP_LOAD : OP_NOP;
      S_PRE:   cmd.op = OP_PRE;
      S_CAP:   cmd.op = OP_CAP;
      S_RD:    cmd.op = OP_RD;
      S_TANH:  cmd.op = OP_TANH;
      S_MUL1:  cmd.op = OP_MUL1;
      S_SLOPE: cmd.op = OP_SLOPE;
      S_MUL2:  cmd.op = OP_MUL2;
      S_UPD:   cmd.op = OP_UPD;
      S_FRD:   cmd.op = OP_FRD;
      S_FMUL:  cmd.op = OP_FMUL;
      S_FDIV:  cmd.op = OP_FDIV;
      S_FOUT:  cmd.op = OP_FOUT;
      default: cmd.op = OP_NOP;
    endcase
  end

  // The step pass always returns to the first oscillator at a stage boundary.
  a_stage_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PRE) |-> (idx_r == '0))
    else $error("stage started away from oscillator zero");
  a_fout_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FOUT) |-> ($past(state_r) == S_FDIV))
    else $error("final write without division");
  a_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FOUT && last) |=> (state_r == S_IDLE))
    else $error("controller did not return to idle after the last result");

endmodule

[src/corrk4_dpath.sv]
`timescale 1ns / 1ps
module corrk4_dpath #(
  parameter int N_OSC        = corrk4_pkg::N_OSC_DEF,
  parameter int TANH_ENTRIES = corrk4_pkg::TANH_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  corrk4_pkg::cmd_t                    cmd,
  input  corrk4_pkg::in_item_t                in_data,
  input  logic                                cfg_we,
  input  logic [corrk4_pkg::STEP_W-1:0]       cfg_wdata,
  output logic                                out_strobe,
  output corrk4_pkg::out_item_t               out_data
);
  import corrk4_pkg::*;

  localparam int AW  = $clog2(N_OSC);
  localparam int TAW = $clog2(TANH_ENTRIES);
  localparam int EW  = $clog2(TANH_ENTRIES + 1);
  localparam int OW  = 23 + EW;
  localparam logic [30:0] RECIP = 31'd1431655766;
  localparam logic [33:0] OFS   = 34'd201326592;

  // Tanh table of constants, one entry per bin midpoint.
  logic signed [TANH_W-1:0] tanh_rom [TANH_ENTRIES];
  for (genvar g = 0; g < TANH_ENTRIES; g++) begin : g_tab
    localparam longint MID = ((longint'(2 * g + 1)) <<< 22) / TANH_ENTRIES
                             - (longint'(1) <<< 22);
    assign tanh_rom[g] = tanh_fixed(MID);
  end

  // Stores.
  logic signed [PHASE_W-1:0] ph_mem [N_OSC];
  logic signed [RATE_W-1:0]  rate_mem [N_OSC];
  logic signed [RATE_W-1:0]  gain_mem [N_OSC];
  logic signed [SUM_W-1:0]   sum_mem [N_OSC];
  logic signed [PHASE_W-1:0] tr_mem [N_OSC];
  logic [N_OSC-1:0]          pvld_r, rvld_r;

  logic signed [PHASE_W-1:0] ph_rd_r, tr_rd_r;
  logic signed [RATE_W-1:0]  rate_rd_r, gain_rd_r;
  logic signed [SUM_W-1:0]   sum_rd_r;
  logic                      vph_r, vrg_r;

  logic [STEP_W-1:0]         step_r;
  logic signed [PHASE_W-1:0] cur_r, src0_r, nb_r, x_r;
  logic signed [RATE_W-1:0]  rate_r, gain_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [TANH_W-1:0]  tanh_r;
  logic signed [45:0]        prod_r;
  logic signed [SLOPE_W-1:0] k_r;
  logic signed [46:0]        kh_r;
  logic signed [52:0]        p_r;
  logic [60:0]               qm_r;
  logic                      out_strobe_r;
  out_item_t                 out_item_r;

  logic                      ld_we;
  logic [AW-1:0]             ph_ra, tr_ra, ia;
  logic                      ph_we;
  logic [AW-1:0]             ph_wa;
  logic signed [PHASE_W-1:0] ph_wd;
  logic signed [PHASE_W-1:0] ph_v, src_v, next_v, xv, dv, ph_new;
  logic signed [RATE_W-1:0]  rate_v, gain_v;
  logic signed [TANH_W-1:0]  tanh_v;
  logic signed [45:0]        slope_full;
  logic signed [SUM_W-1:0]   sum_wd;
  logic signed [PHASE_W-1:0] tr_wd;
  logic signed [46:0]        kh_rnd;
  logic signed [53:0]        pr;
  logic signed [33:0]        qv;
  logic [33:0]               xs;
  logic signed [SUM_W-1:0]   dlt;

  assign ia    = cmd.idx[AW-1:0];
  assign ld_we = (cmd.op == OP_LOAD) && (int'(in_data.oscillator_index) < N_OSC);

  // Read addresses: stage one reads the neighbour from the phase store.
  always_comb begin
    ph_ra = ia;
    tr_ra = cmd.idx_nx[AW-1:0];
    if (cmd.op == OP_PRE) begin
      ph_ra = '0;
      tr_ra = '0;
    end else if (cmd.op == OP_RD && cmd.stage == STAGE_K1) begin
      ph_ra = cmd.idx_nx[AW-1:0];
    end
  end

  // Phase store write: a load or the final update.
  always_comb begin
    ph_we = ld_we || (cmd.op == OP_FOUT);
    ph_wa = ld_we ? in_data.oscillator_index[AW-1:0] : ia;
    ph_wd = ld_we ? in_data.phase_value : ph_new;
  end

  always_ff @(posedge clk) begin
    if (ph_we) ph_mem[ph_wa] <= ph_wd;
    ph_rd_r <= ph_mem[ph_ra];
    vph_r   <= pvld_r[ph_ra];
  end

  always_ff @(posedge clk) begin
    if (ld_we) begin
      rate_mem[in_data.oscillator_index[AW-1:0]] <= in_data.natural_rate;
      gain_mem[in_data.oscillator_index[AW-1:0]] <= in_data.coupling_gain;
    end
    rate_rd_r <= rate_mem[ia];
    gain_rd_r <= gain_mem[ia];
    vrg_r     <= rvld_r[ia];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_MUL2) sum_mem[ia] <= sum_wd;
    sum_rd_r <= sum_mem[ia];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_UPD && cmd.stage != STAGE_K4) tr_mem[ia] <= tr_wd;
    tr_rd_r <= tr_mem[tr_ra];
  end

  // Valid bits stand for the all-zero reset of the loaded stores.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= '0;
      rvld_r <= '0;
    end else begin
      if (ph_we) pvld_r[ph_wa] <= 1'b1;
      if (ld_we) rvld_r[in_data.oscillator_index[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else if (cfg_we) begin
      step_r <= cfg_wdata;
    end
  end

  // Masked read data and the operands of the slope.
  always_comb begin
    ph_v   = vph_r ? ph_rd_r : '0;
    rate_v = vrg_r ? rate_rd_r : '0;
    gain_v = vrg_r ? gain_rd_r : '0;
    src_v  = (cmd.stage == STAGE_K1) ? ph_v : tr_rd_r;
    next_v = cmd.last ? src0_r : src_v;
    xv     = (cmd.stage == STAGE_K1) ? cur_r : ph_v;
    dv     = next_v - cur_r;
  end

  // Nearest-entry tanh lookup with saturation outside [-4, 4).
  always_comb begin
    logic [22:0]   off;
    logic [OW-1:0] sc;
    logic [OW-1:0] ix;
    off = 23'(dv + 32'sd4194304);
    sc  = OW'(off) * OW'(TANH_ENTRIES);
    ix  = sc >> 23;
    if (ix > OW'(TANH_ENTRIES - 1)) ix = OW'(TANH_ENTRIES - 1);
    if (dv < -32'sd4194304) begin
      tanh_v = -TANH_W'(32'sd1048576);
    end else if (dv >= 32'sd4194304) begin
      tanh_v = TANH_W'(32'sd1048576);
    end else begin
      tanh_v = tanh_rom[ix[TAW-1:0]];
    end
  end

  // Slope, weighted sum and trial phase.
  always_comb begin
    logic signed [SLOPE_W:0] wk;
    logic signed [SUM_W-1:0] base;
    slope_full = $signed({{(46 - RATE_W){rate_r[RATE_W-1]}}, rate_r})
               + ((prod_r + 46'sd524288) >>> 20);
    wk   = (cmd.stage == STAGE_K2 || cmd.stage == STAGE_K3) ?
           {k_r, 1'b0} : {k_r[SLOPE_W-1], k_r};
    base = (cmd.stage == STAGE_K1) ? '0 : sum_r;
    sum_wd = base + SUM_W'(wk);
    if (cmd.stage == STAGE_K3) begin
      kh_rnd = (kh_r + 47'sd524288) >>> 20;
    end else begin
      kh_rnd = (kh_r + 47'sd1048576) >>> 21;
    end
    tr_wd = x_r + PHASE_W'(kh_rnd);
  end

  // Final update: floor division by six times 2^20 through a reciprocal.
  always_comb begin
    pr     = {p_r[52], p_r} + 54'sd3145728;
    qv     = 34'(pr >>> 20);
    xs     = $unsigned(qv) + OFS;
    dlt    = SUM_W'(qm_r >> 33) - SUM_W'(32'd33554432);
    ph_new = x_r + dlt;
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CAP: begin
        cur_r  <= src_v;
        src0_r <= src_v;
      end
      OP_TANH: begin
        tanh_r <= tanh_v;
        nb_r   <= next_v;
        x_r    <= xv;
        rate_r <= rate_v;
        gain_r <= gain_v;
        sum_r  <= sum_rd_r;
      end
      OP_MUL1:  prod_r <= gain_r * tanh_r;
      OP_SLOPE: k_r    <= slope_full[SLOPE_W-1:0];
      OP_MUL2:  kh_r   <= k_r * $signed({1'b0, step_r});
      OP_UPD:   cur_r  <= nb_r;
      OP_FMUL: begin
        x_r <= ph_v;
        p_r <= sum_rd_r * $signed({1'b0, step_r});
      end
      OP_FDIV:  qm_r <= 61'(xs[29:0]) * 61'(RECIP);
      OP_FOUT: begin
        out_item_r.result_index <= cmd.idx;
        out_item_r.result_phase <= ph_new;
        out_item_r.last_of_run  <= cmd.last;
      end
      default: begin
      end
    endcase
  end

  // Result strobe, one cycle per transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (cmd.op == OP_FOUT);
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_item_r;

  // A final write refers to an oscillator of the ring.
  a_fout_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FOUT) |-> (int'(cmd.idx) < N_OSC))
    else $error("final write outside the ring");
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(cmd.op) == OP_FOUT))
    else $error("result strobe without a final write");
  a_trial_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_LOAD) |-> !(ph_we && ph_wa != in_data.oscillator_index[AW-1:0]))
    else $error("load wrote the wrong phase entry");

endmodule

[src/coupled_oscillator_ring_rk4_step_core.sv]
`timescale 1ns / 1ps
// Ring of phase oscillators advanced by a fourth-order Runge-Kutta step.
// Input channel: a transaction is taken at a rising edge with start high and
// busy low. A load transaction writes one oscillator in that edge (an index
// of N_OSC or above writes nothing), returns no result and leaves busy low,
// so loads may follow every cycle. A step transaction raises busy while it
// runs: each of the four stages fetches the first phase, then takes every
// oscillator through the shared tanh lookup, gain multiplier and step
// multiplier; a final pass over the oscillators applies the weighted slope
// sum through a reciprocal divider.
// Results: one transaction per oscillator, in index order, each shown on
// out_data for exactly one cycle with out_strobe; the last carries
// last_of_run. The receiver cannot stall, so results are never held.
// Configuration: cfg_we writes the step size at once; write it only while
// busy is low. Reset (rst_n low, synchronous) clears phases, rates and
// gains to zero, restores the default step size and ends any step.
module coupled_oscillator_ring_rk4_step_core #(
  parameter int N_OSC        = corrk4_pkg::N_OSC_DEF,
  parameter int TANH_ENTRIES = corrk4_pkg::TANH_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  corrk4_pkg::in_item_t          in_data,
  input  logic                          cfg_we,
  input  logic [corrk4_pkg::STEP_W-1:0] cfg_wdata,
  output logic                          out_strobe,
  output corrk4_pkg::out_item_t         out_data
);
  import corrk4_pkg::*;

  cmd_t cmd;

  corrk4_ctrl #(.N_OSC(N_OSC)) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_data.opcode),
    .busy   (busy),
    .cmd    (cmd)
  );

  corrk4_dpath #(.N_OSC(N_OSC), .TANH_ENTRIES(TANH_ENTRIES)) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.opcode == OPC_STEP) |=> busy)
    else $error("step transaction did not raise busy");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.opcode == OPC_LOAD) |=> !busy)
    else $error("load transaction raised busy");
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.last_of_run) |=> !out_strobe)
    else $error("result after the last of a step");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import corrk4_pkg::*;

  localparam int RING_SIZE   = 8;
  localparam int TABLE_SIZE  = 256;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int STEP_CYCLES = 8 + 28 * RING_SIZE + 4 * RING_SIZE + 16;

  // Keeps a private copy of the oscillator ring and predicts every reported phase.
  class phase_ring_board;
    bit [31:0]          phase_mem[RING_SIZE];
    bit signed [23:0]   rate_mem[RING_SIZE];
    bit signed [23:0]   gain_mem[RING_SIZE];
    bit [19:0]          step_h;
    longint             tanh_lut[TABLE_SIZE];
    out_item_t          pending[$];
    int                 errors;

    function new();
      longint mid;
      errors = 0;
      step_h = STEP_RESET;
      for (int i = 0; i < RING_SIZE; i++) begin
        phase_mem[i] = '0;
        rate_mem[i]  = '0;
        gain_mem[i]  = '0;
      end
      for (int i = 0; i < TABLE_SIZE; i++) begin
        mid = longint'(((64'(2 * i + 1)) << 22) / TABLE_SIZE) - (longint'(1) << 22);
        tanh_lut[i] = tanh_of_mid(mid);
      end
    endfunction

    // Tanh built from exp(-2|x|) by a short series followed by repeated squaring.
    function longint tanh_of_mid(longint x);
      bit [63:0] mag;
      bit [63:0] unity;
      bit [63:0] a;
      bit [63:0] a2;
      bit [63:0] a3;
      bit [63:0] a4;
      bit [63:0] ex;
      bit [63:0] den;
      bit [63:0] q;
      mag   = (x < 0) ? 64'(-x) : 64'(x);
      unity = 64'd1 << 30;
      a     = (2 * mag) << 4;
      a2    = (a * a) >> 30;
      a3    = (a2 * a) >> 30;
      a4    = (a3 * a) >> 30;
      ex    = unity - a + a2 / 2 - a3 / 6 + a4 / 24;
      for (int s = 0; s < 6; s++) ex = (ex * ex) >> 30;
      den = unity + ex;
      q   = (((unity - ex) << 20) + den / 2) / den;
      return (x < 0) ? -longint'(q) : longint'(q);
    endfunction

    function longint tanh_read(longint d);
      longint lim;
      lim = longint'(1) << 22;
      if (d < -lim) return -(longint'(1) << 20);
      if (d >= lim) return longint'(1) << 20;
      return tanh_lut[((d + lim) * TABLE_SIZE) >>> 23];
    endfunction

    function longint slope_at(int i, bit [31:0] ph[RING_SIZE]);
      bit [31:0] diff;
      longint    prod;
      diff = ph[(i + 1) % RING_SIZE] - ph[i];
      prod = longint'(gain_mem[i]) * tanh_read(longint'($signed(diff)));
      return longint'(rate_mem[i]) + ((prod + (longint'(1) << 19)) >>> 20);
    endfunction

    // An accepted input transaction: a load updates the ring, a step queues all phases.
    function void note_input(in_item_t it);
      bit [31:0]       trial[RING_SIZE];
      bit signed [31:0] sum[RING_SIZE];
      longint          k[RING_SIZE];
      longint          h;
      longint          delta;
      longint          p;
      longint          dv;
      out_item_t       res;
      if (it.opcode == OPC_LOAD) begin
        if (it.oscillator_index < RING_SIZE) begin
          phase_mem[it.oscillator_index] = it.phase_value;
          rate_mem[it.oscillator_index]  = it.natural_rate;
          gain_mem[it.oscillator_index]  = it.coupling_gain;
        end
        return;
      end
      h = longint'(step_h);
      trial = phase_mem;
      for (int st = 0; st < 4; st++) begin
        for (int i = 0; i < RING_SIZE; i++)
          k[i] = (st == 0) ? slope_at(i, phase_mem) : slope_at(i, trial);
        for (int i = 0; i < RING_SIZE; i++) begin
          if (st == 0) sum[i] = 32'(k[i]);
          else sum[i] = 32'(longint'(sum[i]) + ((st == 3) ? 1 : 2) * k[i]);
          if (st < 2) delta = (k[i] * h + (longint'(1) << 20)) >>> 21;
          else if (st == 2) delta = (k[i] * h + (longint'(1) << 19)) >>> 20;
          else delta = 0;
          trial[i] = phase_mem[i] + 32'(delta);
        end
      end
      dv = longint'(6) << 20;
      for (int i = 0; i < RING_SIZE; i++) begin
        p = longint'(sum[i]) * h + (longint'(3) << 20);
        delta = (p >= 0) ? p / dv : -((-(p + 1)) / dv) - 1;
        phase_mem[i] = phase_mem[i] + 32'(delta);
        res.result_index = IDX_W'(i);
        res.result_phase = phase_mem[i];
        res.last_of_run  = (i == RING_SIZE - 1);
        pending.insert(pending.size(), res);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result index %0d phase %0h", $time,
                 got.result_index, got.result_phase);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.result_index !== want.result_index) begin
        $display("%0t: result_index expected %0d actual %0d", $time,
                 want.result_index, got.result_index);
        errors++;
      end
      if (got.result_phase !== want.result_phase) begin
        $display("%0t: result_phase expected %0h actual %0h", $time,
                 want.result_phase, got.result_phase);
        errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $display("%0t: last_of_run expected %0b actual %0b", $time,
                 want.last_of_run, got.last_of_run);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_item_t          in_data;
  logic              cfg_we;
  logic [STEP_W-1:0] cfg_wdata;
  logic              out_strobe;
  out_item_t         out_data;
  int                idle_pct;
  int unsigned       cycles;
  phase_ring_board   board;

  coupled_oscillator_ring_rk4_step_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every result transaction is checked at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_strobe) board.check_result(out_data);
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Called at a rising edge; leaves start high so a back-to-back transaction follows.
  task automatic send_item(in_item_t it);
    int gap;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    board.note_input(it);
  endtask

  // Waits until the ring is quiet, then writes a new step size.
  task automatic write_step(logic [STEP_W-1:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (STEP_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.step_h = v;
  endtask

  function automatic in_item_t make_load(int idx, logic [31:0] ph, logic [23:0] rt,
                                         logic [23:0] gn);
    in_item_t it;
    it.opcode           = OPC_LOAD;
    it.oscillator_index = IDX_W'(idx);
    it.phase_value      = ph;
    it.natural_rate     = rt;
    it.coupling_gain    = gn;
    return it;
  endfunction

  function automatic in_item_t make_step();
    in_item_t it;
    it = make_load($urandom_range(63), $urandom, 24'($urandom), 24'($urandom));
    it.opcode = OPC_STEP;
    return it;
  endfunction

  // Mostly loads into the ring, some ignored loads, and a fair share of steps.
  function automatic in_item_t random_item();
    int r;
    r = $urandom_range(99);
    if (r < 30) return make_step();
    if (r < 38)
      return make_load($urandom_range(RING_SIZE, 63), $urandom, 24'($urandom),
                       24'($urandom));
    if (r < 60)
      return make_load($urandom_range(RING_SIZE - 1), $urandom_range(0, 32'h00ff_ffff)
                       - 32'h0080_0000, 24'($urandom), 24'($urandom));
    return make_load($urandom_range(RING_SIZE - 1), $urandom, 24'($urandom),
                     24'($urandom));
  endfunction

  initial begin
    board     = new();
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    idle_pct  = 21;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a step from the reset state, extreme loads, ignored loads,
    // differences beyond the tanh range on both sides and within it.
    send_item(make_step());
    send_item(make_load(0, 32'h7fff_ffff, 24'h7f_ffff, 24'h7f_ffff));
    send_item(make_load(1, 32'h8000_0000, 24'h80_0000, 24'h80_0000));
    send_item(make_load(2, 32'h0000_0000, 24'h00_0000, 24'h7f_ffff));
    send_item(make_load(3, 32'h0040_0000, 24'h10_0000, 24'h80_0000));
    send_item(make_load(4, 32'h003f_ffff, 24'hf0_0000, 24'h40_0000));
    send_item(make_load(5, 32'hffc0_0000, 24'h00_0001, 24'hc0_0000));
    send_item(make_load(6, 32'hffbf_ffff, 24'hff_ffff, 24'h10_0000));
    send_item(make_load(7, 32'hffff_ffff, 24'h08_0000, 24'hf0_0000));
    send_item(make_load(8, 32'h1234_5678, 24'h7f_ffff, 24'h7f_ffff));
    send_item(make_load(63, 32'hffff_ffff, 24'hff_ffff, 24'hff_ffff));
    send_item(make_step());
    send_item(make_step());
    send_item(make_load(7, 32'h0000_0000, 24'h00_0000, 24'h00_0000));
    send_item(make_step());

    // Hold off until the ring has reported everything, then try the extremes.
    write_step(20'hf_ffff);
    send_item(make_step());
    send_item(make_step());
    write_step(20'h0_0000);
    send_item(make_step());
    write_step(20'h0_0001);
    send_item(make_step());

    // Random: three idling regimes, each under its own step size.
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 21 : (ph == 1) ? 81 : 0;
      write_step((ph == 2) ? STEP_RESET : 20'($urandom));
      for (int n = 0; n < 78; n++) send_item(random_item());
    end

    start <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (STEP_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[coupled_oscillator_ring_rk4_step_core.f]
src/corrk4_pkg.sv
src/corrk4_ctrl.sv
src/corrk4_dpath.sv
src/coupled_oscillator_ring_rk4_step_core.sv
tb/testbench.sv
